// ----- sv/rbse_pkg.sv -----
// rbse_pkg: shared constants, codes, command/status types and the state
// transition function of the resync bitmap state engine. No dependencies.
`timescale 1ns / 1ps
package rbse_pkg;

    localparam int MAX_CHUNKS     = 130048;
    localparam int HEADER_ENTRIES = 1024;
    localparam int STORE_ENTRIES  = 131072;

    localparam int CW = 17;   // chunk index width
    localparam int SW = 3;    // stored state width

    // chunk states
    localparam logic [SW-1:0] ST_UNW   = 3'd0;
    localparam logic [SW-1:0] ST_CLEAN = 3'd1;
    localparam logic [SW-1:0] ST_DIRTY = 3'd2;
    localparam logic [SW-1:0] ST_NSYNC = 3'd3;
    localparam logic [SW-1:0] ST_NONE  = 3'd5;

    // modes
    localparam logic [3:0] MODE_WRITE = 4'd0;
    localparam logic [3:0] MODE_STALE = 4'd7;
    localparam logic [3:0] MODE_INIT  = 4'd8;
    localparam logic [3:0] MODE_FLUSH = 4'd9;

    // register indexes
    localparam logic [2:0] REG_PARITY = 3'd0;
    localparam logic [2:0] REG_HALT   = 3'd1;
    localparam logic [2:0] REG_SCLEAN = 3'd2;
    localparam logic [2:0] REG_CCOUNT = 3'd3;
    localparam logic [2:0] REG_BSHIFT = 3'd4;

    // kind of work decided at load
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_FLUSH = 2'd1;
    localparam logic [1:0] K_INIT  = 2'd2;
    localparam logic [1:0] K_WALK  = 2'd3;

    typedef struct packed {
        logic          parity;
        logic          halt;
        logic          sclean;
        logic [CW-1:0] n;      // live chunk count
        logic [3:0]    sh;     // live block shift, 9..12
    } t_cfg;

    typedef struct packed {
        logic load;
        logic clr;
        logic init_wr;
        logic rd_pos;
        logic rd_sp;
        logic eval;
        logic adv;
        logic sp_inc;
        logic inf_start;
        logic inf_ev;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       clr_last;
        logic       at_end;
        logic       ev_mark;
        logic       ev_was;
        logic       sp_end;
        logic       found;
    } t_sts;

    function automatic logic [SW-1:0] f_next(input logic [SW-1:0] cur,
                                             input logic [2:0] mode);
        logic [8*SW-1:0] row;
        begin
            case (cur)
                3'd0: row = {3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd2};
                3'd1: row = {3'd3, 3'd0, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd2};
                3'd2: row = {3'd3, 3'd0, 3'd1, 3'd3, 3'd5, 3'd5, 3'd5, 3'd5};
                3'd3: row = {3'd5, 3'd0, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd5};
                3'd4: row = {3'd3, 3'd0, 3'd5, 3'd3, 3'd3, 3'd2, 3'd4, 3'd5};
                default: row = {8{ST_NONE}};
            endcase
            f_next = row[mode*SW +: SW];
        end
    endfunction

endpackage

// ----- sv/rbse_dp.sv -----
// rbse_dp: datapath - chunk state store, block dirty marks, walk and block
// pointers, result flags. Depends on rbse_pkg; driven by rbse_ctrl commands.
`timescale 1ns / 1ps
module rbse_dp #(
    parameter int HEADER_ENTRIES = rbse_pkg::HEADER_ENTRIES,
    parameter int STORE_ENTRIES  = rbse_pkg::STORE_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rbse_pkg::t_cfg             i_cfg,
    input  rbse_pkg::t_cmd             i_cmd,
    output rbse_pkg::t_sts             o_sts,
    input  logic [3:0]                 i_mode,
    input  logic [rbse_pkg::CW-1:0]    i_first_chunk,
    input  logic [rbse_pkg::CW-1:0]    i_last_chunk,
    output logic [rbse_pkg::SW-1:0]    o_final_state,
    output logic                       o_resync_due,
    output logic                       o_recovery_deferred,
    output logic                       o_arm_timer,
    output logic                       o_block_was_dirty
);
    localparam int AW  = $clog2(STORE_ENTRIES);
    localparam int PW  = $clog2(STORE_ENTRIES + HEADER_ENTRIES + 2**rbse_pkg::CW + 1);
    localparam int MC  = (STORE_ENTRIES + 511) / 512;
    localparam int MCW = (MC > 1) ? $clog2(MC) : 1;
    localparam int SW  = rbse_pkg::SW;
    localparam logic [PW-1:0] HP    = PW'(HEADER_ENTRIES);
    localparam logic [PW-1:0] LASTP = PW'(STORE_ENTRIES - 1);
    localparam logic [PW-1:0] MCP   = PW'(MC);

    logic [SW-1:0] mem [STORE_ENTRIES];
    logic [SW-1:0] r_rdata;
    // block dirty marks, one registered read a cycle at the current block
    logic          mark_mem [MC];
    logic          r_mrd;

    logic [PW-1:0] r_pos, r_end, r_hi, r_sp, r_se, r_sb;
    logic [2:0]    r_mode;
    logic [1:0]    r_kind;
    logic          r_val;
    logic [SW-1:0] r_st;
    logic          r_res, r_rec, r_tmr, r_bwd;

    // load decode
    logic          nz, walk_ok;
    logic [rbse_pkg::CW-1:0] nm1, lastc;
    logic [1:0]    n_kind;

    always_comb begin
        nz      = i_cfg.n != '0;
        nm1     = i_cfg.n - rbse_pkg::CW'(1);
        lastc   = (i_last_chunk > nm1) ? nm1 : i_last_chunk;
        walk_ok = nz && (i_first_chunk < i_cfg.n) && (i_first_chunk <= i_last_chunk);
        if (i_mode == rbse_pkg::MODE_FLUSH) begin
            n_kind = rbse_pkg::K_FLUSH;
        end else if (i_mode <= rbse_pkg::MODE_INIT && !i_cfg.halt) begin
            if (i_mode == rbse_pkg::MODE_INIT) begin
                n_kind = nz ? rbse_pkg::K_INIT : rbse_pkg::K_NONE;
            end else begin
                n_kind = walk_ok ? rbse_pkg::K_WALK : rbse_pkg::K_NONE;
            end
        end else begin
            n_kind = rbse_pkg::K_NONE;
        end
    end

    // evaluation of one walked chunk
    logic [SW-1:0] base, st;
    logic          inv, rec_now, mark;
    logic [PW-1:0] blk, bstart, bend, sp_lo, se_hi;

    always_comb begin
        inv     = r_rdata >= rbse_pkg::ST_NONE;
        base    = rbse_pkg::f_next(r_rdata, r_mode);
        rec_now = !inv && r_rdata == rbse_pkg::ST_UNW && base == rbse_pkg::ST_DIRTY
                  && r_mode == rbse_pkg::MODE_WRITE[2:0] && i_cfg.parity;
        st      = (inv || rec_now) ? rbse_pkg::ST_NSYNC : base;
        mark    = st == rbse_pkg::ST_DIRTY || st == rbse_pkg::ST_NSYNC;
        blk     = r_pos >> i_cfg.sh;
        bstart  = blk << i_cfg.sh;
        bend    = bstart + (PW'(1) << i_cfg.sh);
        sp_lo   = (bstart < HP) ? HP : bstart;
        se_hi   = (bend > r_hi) ? r_hi : bend;
    end

    // memory port
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [SW-1:0] wdata;

    always_comb begin
        we    = 1'b0;
        waddr = r_pos[AW-1:0];
        wdata = st;
        raddr = i_cmd.rd_sp ? r_sp[AW-1:0] : r_pos[AW-1:0];
        if (i_cmd.clr) begin
            we    = 1'b1;
            wdata = rbse_pkg::ST_UNW;
        end else if (i_cmd.init_wr) begin
            we    = 1'b1;
            wdata = r_val ? rbse_pkg::ST_CLEAN : rbse_pkg::ST_UNW;
        end else if (i_cmd.eval) begin
            we    = st != rbse_pkg::ST_NONE;
        end else if (i_cmd.inf_ev) begin
            waddr = r_sp[AW-1:0];
            we    = (r_sp != r_pos) && (r_rdata == rbse_pkg::ST_UNW ||
                                        r_rdata == rbse_pkg::ST_CLEAN);
            wdata = (r_rdata == rbse_pkg::ST_UNW && i_cfg.parity) ?
                    rbse_pkg::ST_NSYNC : rbse_pkg::ST_DIRTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // mark port: cleared by the reset pass, set on eval, cleared on flush
    logic           mwe, mwd;
    logic [MCW-1:0] mwaddr;

    always_comb begin
        mwe    = 1'b0;
        mwd    = 1'b0;
        mwaddr = blk[MCW-1:0];
        if (i_cmd.clr) begin
            mwe    = r_pos < MCP;
            mwaddr = r_pos[MCW-1:0];
        end else if (i_cmd.eval) begin
            mwe = mark;
            mwd = 1'b1;
        end else if (i_cmd.flush) begin
            mwe = blk < MCP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mwe) begin
            mark_mem[mwaddr] <= mwd;
        end
        r_mrd <= mark_mem[blk[MCW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_kind  <= rbse_pkg::K_NONE;
        end else begin
            if (i_cmd.load) begin
                r_kind <= n_kind;
                if (i_mode == rbse_pkg::MODE_INIT) begin
                    r_pos <= HP;
                    r_end <= HP + PW'(nm1);
                end else begin
                    r_pos <= HP + PW'(i_first_chunk);
                    r_end <= HP + PW'(lastc);
                end
            end
            if (i_cmd.clr) begin
                r_pos <= o_sts.clr_last ? '0 : r_pos + PW'(1);
            end
            if (i_cmd.init_wr || i_cmd.adv) begin
                r_pos <= r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode[2:0];
            r_hi   <= HP + PW'(i_cfg.n);
            r_val  <= i_cfg.sclean;
            r_st   <= rbse_pkg::ST_NONE;
            r_res  <= 1'b0;
            r_rec  <= 1'b0;
            r_tmr  <= 1'b0;
            r_bwd  <= 1'b0;
        end
        if (i_cmd.eval) begin
            r_st <= st;
            if ((!inv && r_rdata == rbse_pkg::ST_NSYNC) || st == rbse_pkg::ST_NSYNC) begin
                r_res <= 1'b1;
            end
            if (rec_now) begin
                r_rec <= 1'b1;
            end
            if (st == rbse_pkg::ST_DIRTY) begin
                r_tmr <= 1'b1;
            end
            if (mark) begin
                r_sp <= sp_lo;
                r_sb <= sp_lo;
                r_se <= se_hi;
            end
        end
        if (i_cmd.sp_inc || i_cmd.inf_ev) begin
            r_sp <= r_sp + PW'(1);
        end
        if (i_cmd.inf_start) begin
            r_sp <= r_sb;
        end
        if (i_cmd.flush && blk < MCP) begin
            r_bwd <= r_mrd;
        end
    end

    always_comb begin
        o_sts.kind     = r_kind;
        o_sts.clr_last = r_pos == LASTP;
        o_sts.at_end   = r_pos == r_end;
        o_sts.ev_mark  = mark;
        o_sts.ev_was   = r_mrd;
        o_sts.sp_end   = r_sp == r_se;
        o_sts.found    = (r_sp != r_pos) && (r_rdata == rbse_pkg::ST_DIRTY ||
                                             r_rdata == rbse_pkg::ST_NSYNC);
    end

    assign o_final_state       = r_st;
    assign o_resync_due        = r_res && !r_rec;
    assign o_recovery_deferred = r_rec;
    assign o_arm_timer         = r_tmr;
    assign o_block_was_dirty   = r_bwd;

endmodule

// ----- sv/rbse_ctrl.sv -----
// rbse_ctrl: sequencer for clearing, init sweep, flush, range walk, block scan and
// infection passes. Depends on rbse_pkg; commands rbse_dp.
`timescale 1ns / 1ps
module rbse_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output logic           o_done,
    input  rbse_pkg::t_sts i_sts,
    output rbse_pkg::t_cmd o_cmd
);
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECIDE = 4'd2;
    localparam logic [3:0] S_FLUSH  = 4'd3;
    localparam logic [3:0] S_INIT   = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_EV     = 4'd6;
    localparam logic [3:0] S_SC_RD  = 4'd7;
    localparam logic [3:0] S_SC_EV  = 4'd8;
    localparam logic [3:0] S_IN_RD  = 4'd9;
    localparam logic [3:0] S_IN_EV  = 4'd10;
    localparam logic [3:0] S_NEXT   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (i_sts.kind)
                    rbse_pkg::K_FLUSH: n_state = S_FLUSH;
                    rbse_pkg::K_INIT:  n_state = S_INIT;
                    rbse_pkg::K_WALK:  n_state = S_RD;
                    default:           n_state = S_DONE;
                endcase
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_DONE;
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.at_end) n_state = S_DONE;
            end
            S_RD: begin
                o_cmd.rd_pos = 1'b1;
                n_state      = S_EV;
            end
            S_EV: begin
                o_cmd.eval = 1'b1;
                if (i_sts.ev_mark) begin
                    n_state = i_sts.ev_was ? S_IN_RD : S_SC_RD;
                end else if (i_sts.at_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_SC_RD: begin
                if (i_sts.sp_end) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.rd_sp = 1'b1;
                    n_state     = S_SC_EV;
                end
            end
            S_SC_EV: begin
                if (i_sts.found) begin
                    o_cmd.inf_start = 1'b1;
                    n_state         = S_IN_RD;
                end else begin
                    o_cmd.sp_inc = 1'b1;
                    n_state      = S_SC_RD;
                end
            end
            S_IN_RD: begin
                if (i_sts.sp_end) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.rd_sp = 1'b1;
                    n_state     = S_IN_EV;
                end
            end
            S_IN_EV: begin
                o_cmd.inf_ev = 1'b1;
                n_state      = S_IN_RD;
            end
            S_NEXT: begin
                if (i_sts.at_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_state == S_DONE;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> r_state == S_CLEAR)
        else $error("reset did not start the clearing pass");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !o_busy)
        else $error("result strobe longer than one cycle");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("result shown while accepting");
    a_adv_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.adv |-> !i_sts.at_end)
        else $error("walk advanced past the range end");

endmodule

// ----- sv/resync_bitmap_state_engine_unit.sv -----
// Resync bitmap state engine top: APB registers, rbse_ctrl, rbse_dp (rbse_pkg).
// Walk: each chunk of the range is read, then evaluated. A chunk set dirty/needsync
// adds a scan and infection pass over the entries of its block. Init writes
// every live chunk.
// Throughput: one item at a time; next start taken the cycle after the strobe.
// Reset: clearing pass of store and marks, busy high; no stall.
`timescale 1ns / 1ps
module resync_bitmap_state_engine_unit #(
    parameter int MAX_CHUNKS     = rbse_pkg::MAX_CHUNKS,
    parameter int HEADER_ENTRIES = rbse_pkg::HEADER_ENTRIES,
    parameter int STORE_ENTRIES  = rbse_pkg::STORE_ENTRIES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // command channel
    input  logic                    start,
    output logic                    busy,
    input  logic [3:0]              i_mode,
    input  logic [rbse_pkg::CW-1:0] i_first_chunk,
    input  logic [rbse_pkg::CW-1:0] i_last_chunk,
    // result channel
    output logic                    o_done,
    output logic [rbse_pkg::SW-1:0] o_final_state,
    output logic                    o_resync_due,
    output logic                    o_recovery_deferred,
    output logic                    o_arm_timer,
    output logic                    o_block_was_dirty,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [4:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int CW = rbse_pkg::CW;
    // chunks the store can hold after the header, at most MAX_CHUNKS
    localparam longint CAP = (HEADER_ENTRIES >= STORE_ENTRIES) ? 0 :
        ((MAX_CHUNKS < STORE_ENTRIES - HEADER_ENTRIES) ? MAX_CHUNKS :
         STORE_ENTRIES - HEADER_ENTRIES);

    logic          r_parity, r_halt, r_sclean;
    logic [CW-1:0] r_ccount;
    logic [3:0]    r_bshift;

    logic          wr;
    logic [2:0]    idx;
    logic          accept;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign accept = start && !busy;

    // Register file. Init consumes start_clean when it is actually taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
            r_halt   <= 1'b0;
            r_sclean <= 1'b0;
            r_ccount <= CW'(rbse_pkg::MAX_CHUNKS);
            r_bshift <= 4'd9;
        end else begin
            if (wr) begin
                case (idx)
                    rbse_pkg::REG_PARITY: r_parity <= pwdata[0];
                    rbse_pkg::REG_HALT:   r_halt   <= pwdata[0];
                    rbse_pkg::REG_SCLEAN: r_sclean <= pwdata[0];
                    rbse_pkg::REG_CCOUNT: r_ccount <= pwdata[CW-1:0];
                    rbse_pkg::REG_BSHIFT: r_bshift <= pwdata[3:0];
                    default: ;
                endcase
            end
            if (accept && i_mode == rbse_pkg::MODE_INIT && !r_halt) begin
                r_sclean <= 1'b0;
            end
        end
    end

    always_comb begin
        case (idx)
            rbse_pkg::REG_PARITY: prdata = {31'd0, r_parity};
            rbse_pkg::REG_HALT:   prdata = {31'd0, r_halt};
            rbse_pkg::REG_SCLEAN: prdata = {31'd0, r_sclean};
            rbse_pkg::REG_CCOUNT: prdata = {{(32-CW){1'b0}}, r_ccount};
            rbse_pkg::REG_BSHIFT: prdata = {28'd0, r_bshift};
            default:              prdata = 32'd0;
        endcase
    end

    // live view of the registers: count and shift saturated
    rbse_pkg::t_cfg cfg;
    always_comb begin
        cfg.parity = r_parity;
        cfg.halt   = r_halt;
        cfg.sclean = r_sclean;
        cfg.n      = (longint'(r_ccount) > CAP) ? CW'(CAP) : r_ccount;
        cfg.sh     = (r_bshift < 4'd9) ? 4'd9 : ((r_bshift > 4'd12) ? 4'd12 : r_bshift);
    end

    rbse_pkg::t_cmd cmd;
    rbse_pkg::t_sts sts;

    rbse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rbse_dp #(
        .HEADER_ENTRIES (HEADER_ENTRIES),
        .STORE_ENTRIES  (STORE_ENTRIES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg               (cfg),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_mode              (i_mode),
        .i_first_chunk       (i_first_chunk),
        .i_last_chunk        (i_last_chunk),
        .o_final_state       (o_final_state),
        .o_resync_due        (o_resync_due),
        .o_recovery_deferred (o_recovery_deferred),
        .o_arm_timer         (o_arm_timer),
        .o_block_was_dirty   (o_block_was_dirty)
    );

endmodule

// ----- dv/tb.sv -----
// tb: self-checking bench for resync_bitmap_state_engine_unit. Holds its own
// copy of the chunk states and block marks. Depends on rbse_pkg and the top level.
`timescale 1ns / 1ps
module tb;
    localparam int CW             = rbse_pkg::CW;
    localparam int SW             = rbse_pkg::SW;
    localparam int TIMEOUT_CYCLES = 200_000_000;
    localparam int MARK_SLOTS     = (rbse_pkg::STORE_ENTRIES + 511) / 512;

    localparam logic [SW-1:0] ST_SYNCING = 3'd4;

    // mode codes the package does not name
    localparam logic [3:0] MODE_SYNC    = 4'd1;
    localparam logic [3:0] MODE_ENDSYNC = 4'd2;
    localparam logic [3:0] MODE_ABORT   = 4'd3;
    localparam logic [3:0] MODE_RELOAD  = 4'd4;
    localparam logic [3:0] MODE_DAEMON  = 4'd5;
    localparam logic [3:0] MODE_DISCARD = 4'd6;
    localparam logic [3:0] MODE_BAD_LO  = 4'd10;
    localparam logic [3:0] MODE_BAD_HI  = 4'd15;

    typedef struct {
        logic [3:0]    mode;
        logic [CW-1:0] first;
        logic [CW-1:0] last;
    } t_action;

    typedef struct {
        logic [SW-1:0] fstate;
        logic          resync;
        logic          recovery;
        logic          timer;
        logic          was_dirty;
    } t_outcome;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic [3:0]    i_mode = '0;
    logic [CW-1:0] i_first_chunk = '0;
    logic [CW-1:0] i_last_chunk = '0;
    logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    wire           busy, o_done, o_resync_due, o_recovery_deferred, o_arm_timer;
    wire           o_block_was_dirty, pready;
    wire [SW-1:0]  o_final_state;
    wire [31:0]    prdata;

    resync_bitmap_state_engine_unit dut (.*);

    initial forever #2 i_clk = ~i_clk;

    // bench copy of the registers and the stores
    logic          r_parity, r_halt, r_sclean;
    logic [CW-1:0] r_count;
    logic [3:0]    r_shift;
    logic [SW-1:0] chunk_st [rbse_pkg::STORE_ENTRIES];
    logic          blk_mark [MARK_SLOTS];

    t_action  pending_actions[$];
    t_outcome expected_outcomes[$];
    t_action  cur_action;
    int       gap_left = 0;
    bit       gaps_on = 1'b1;
    int       fail_count = 0;
    int       cycle_count = 0;

    function automatic logic [SW-1:0] next_state(logic [SW-1:0] cur, logic [3:0] m);
        case (cur)
            rbse_pkg::ST_UNW: begin
                if (m == rbse_pkg::MODE_WRITE) return rbse_pkg::ST_DIRTY;
                return rbse_pkg::ST_NONE;
            end
            rbse_pkg::ST_CLEAN: begin
                if (m == rbse_pkg::MODE_WRITE) return rbse_pkg::ST_DIRTY;
                if (m == MODE_DISCARD) return rbse_pkg::ST_UNW;
                if (m == rbse_pkg::MODE_STALE) return rbse_pkg::ST_NSYNC;
                return rbse_pkg::ST_NONE;
            end
            rbse_pkg::ST_DIRTY: begin
                if (m == MODE_RELOAD || m == rbse_pkg::MODE_STALE) return rbse_pkg::ST_NSYNC;
                if (m == MODE_DAEMON) return rbse_pkg::ST_CLEAN;
                if (m == MODE_DISCARD) return rbse_pkg::ST_UNW;
                return rbse_pkg::ST_NONE;
            end
            rbse_pkg::ST_NSYNC: begin
                if (m == MODE_SYNC) return ST_SYNCING;
                if (m == MODE_DISCARD) return rbse_pkg::ST_UNW;
                return rbse_pkg::ST_NONE;
            end
            default: begin
                if (m == MODE_SYNC) return ST_SYNCING;
                if (m == MODE_ENDSYNC) return rbse_pkg::ST_DIRTY;
                if (m == MODE_ABORT || m == MODE_RELOAD || m == rbse_pkg::MODE_STALE)
                    return rbse_pkg::ST_NSYNC;
                if (m == MODE_DISCARD) return rbse_pkg::ST_UNW;
                return rbse_pkg::ST_NONE;
            end
        endcase
    endfunction

    function automatic int live_count();
        return (r_count > rbse_pkg::MAX_CHUNKS) ? rbse_pkg::MAX_CHUNKS : int'(r_count);
    endfunction

    function automatic int live_shift();
        if (r_shift < 9) return 9;
        if (r_shift > 12) return 12;
        return int'(r_shift);
    endfunction

    // write one chunk; dirty/needsync marks the block and may spread to its chunks
    task automatic store_chunk(int pos, logic [SW-1:0] st, int lo, int hi);
        int  sh, b, p, e;
        bit  was, pend;
        chunk_st[pos] = st;
        if (st != rbse_pkg::ST_DIRTY && st != rbse_pkg::ST_NSYNC) return;
        sh = live_shift();
        b = pos >> sh;
        if (b >= MARK_SLOTS) return;
        was = blk_mark[b];
        blk_mark[b] = 1'b1;
        p = (b << sh) < lo ? lo : (b << sh);
        e = ((b + 1) << sh) > hi ? hi : ((b + 1) << sh);
        pend = 1'b0;
        for (int q = p; q < e; q++)
            if (q != pos && (chunk_st[q] == rbse_pkg::ST_DIRTY ||
                             chunk_st[q] == rbse_pkg::ST_NSYNC)) pend = 1'b1;
        if (!(was || pend)) return;
        for (int q = p; q < e; q++) begin
            if (q == pos) continue;
            if (chunk_st[q] == rbse_pkg::ST_UNW)
                chunk_st[q] = r_parity ? rbse_pkg::ST_NSYNC : rbse_pkg::ST_DIRTY;
            else if (chunk_st[q] == rbse_pkg::ST_CLEAN)
                chunk_st[q] = rbse_pkg::ST_DIRTY;
        end
    endtask

    task automatic predict_outcome(t_action a);
        t_outcome o;
        int n, lo, hi, b, pos, lst;
        logic [SW-1:0] cur, st;
        bit rs, rc, tm, wd;
        n = live_count();
        lo = rbse_pkg::HEADER_ENTRIES;
        hi = rbse_pkg::HEADER_ENTRIES + n;
        st = rbse_pkg::ST_NONE;
        rs = 0; rc = 0; tm = 0; wd = 0;
        if (a.mode == rbse_pkg::MODE_FLUSH) begin
            b = (int'(a.first) + rbse_pkg::HEADER_ENTRIES) >> live_shift();
            if (b < MARK_SLOTS) begin
                wd = blk_mark[b];
                blk_mark[b] = 1'b0;
            end
        end else if (a.mode <= rbse_pkg::MODE_INIT && !r_halt) begin
            if (a.mode == rbse_pkg::MODE_INIT) begin
                cur = r_sclean ? rbse_pkg::ST_CLEAN : rbse_pkg::ST_UNW;
                r_sclean = 1'b0;
                for (int c = 0; c < n; c++)
                    store_chunk(c + rbse_pkg::HEADER_ENTRIES, cur, lo, hi);
            end else if (n > 0 && a.first < n && a.first <= a.last) begin
                lst = (a.last > n - 1) ? n - 1 : int'(a.last);
                for (int c = int'(a.first); c <= lst; c++) begin
                    pos = c + rbse_pkg::HEADER_ENTRIES;
                    cur = chunk_st[pos];
                    if (cur >= rbse_pkg::ST_NONE) begin
                        st = rbse_pkg::ST_NSYNC;       // corrupt stored value
                    end else begin
                        if (cur == rbse_pkg::ST_NSYNC) rs = 1;
                        st = next_state(cur, a.mode);
                        if (st == rbse_pkg::ST_NONE) continue;
                        if (cur == rbse_pkg::ST_UNW && a.mode == rbse_pkg::MODE_WRITE &&
                            r_parity) begin
                            st = rbse_pkg::ST_NSYNC;   // lazy initial recovery
                            rc = 1;
                        end
                    end
                    store_chunk(pos, st, lo, hi);
                    if (st == rbse_pkg::ST_NSYNC) rs = 1;
                    else if (st == rbse_pkg::ST_DIRTY) tm = 1;
                end
            end
        end
        o.fstate = st;
        o.resync = rs && !rc;
        o.recovery = rc;
        o.timer = tm;
        o.was_dirty = wd;
        expected_outcomes.push_back(o);
    endtask

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver: presents queued actions, predicts on each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) predict_outcome(cur_action);
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (pending_actions.size() != 0) begin
                cur_action = pending_actions.pop_front();
                start <= 1'b1;
                i_mode <= cur_action.mode;
                i_first_chunk <= cur_action.first;
                i_last_chunk <= cur_action.last;
                gap_left <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be held off, check each strobe
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_done) begin
            if (expected_outcomes.size() == 0) begin
                $error("unexpected result, final_state %0d", o_final_state);
                fail_count++;
            end else begin
                e = expected_outcomes.pop_front();
                if (o_final_state !== e.fstate) begin
                    $error("final_state exp %0d got %0d", e.fstate, o_final_state);
                    fail_count++;
                end
                if (o_resync_due !== e.resync) begin
                    $error("resync_due exp %0d got %0d", e.resync, o_resync_due);
                    fail_count++;
                end
                if (o_recovery_deferred !== e.recovery) begin
                    $error("recovery_deferred exp %0d got %0d", e.recovery,
                           o_recovery_deferred);
                    fail_count++;
                end
                if (o_arm_timer !== e.timer) begin
                    $error("arm_timer exp %0d got %0d", e.timer, o_arm_timer);
                    fail_count++;
                end
                if (o_block_was_dirty !== e.was_dirty) begin
                    $error("block_was_dirty exp %0d got %0d", e.was_dirty, o_block_was_dirty);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            rbse_pkg::REG_PARITY: r_parity = val[0];
            rbse_pkg::REG_HALT:   r_halt = val[0];
            rbse_pkg::REG_SCLEAN: r_sclean = val[0];
            rbse_pkg::REG_CCOUNT: r_count = val[CW-1:0];
            default:              r_shift = val[3:0];
        endcase
    endtask

    task automatic set_config(bit par, bit halt, bit sc, int cnt, int shf);
        reg_write(rbse_pkg::REG_PARITY, 32'(par));
        reg_write(rbse_pkg::REG_HALT, 32'(halt));
        reg_write(rbse_pkg::REG_SCLEAN, 32'(sc));
        reg_write(rbse_pkg::REG_CCOUNT, 32'(cnt));
        reg_write(rbse_pkg::REG_BSHIFT, 32'(shf));
    endtask

    task automatic push_action(logic [3:0] m, int f, int l);
        t_action a;
        a.mode = m;
        a.first = f[CW-1:0];
        a.last = l[CW-1:0];
        pending_actions.push_back(a);
    endtask

    // wait for every transfer and result, then a short settling pause
    task automatic drain();
        do @(negedge i_clk);
        while (pending_actions.size() != 0 || start || gap_left != 0 ||
               expected_outcomes.size() != 0);
        repeat (10) @(negedge i_clk);
    endtask

    // mostly short writes/syncs near live chunks; some noise
    task automatic fill_random(int count);
        int n, r, f, l;
        logic [3:0] m;
        n = live_count();
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 35) m = rbse_pkg::MODE_WRITE;
            else if (r < 85) m = 4'($urandom_range(1, 7));
            else if (r < 87) m = rbse_pkg::MODE_INIT;
            else if (r < 95) m = rbse_pkg::MODE_FLUSH;
            else m = 4'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
            f = $urandom_range(0, n + 3);
            l = f + $urandom_range(0, 5);
            r = $urandom_range(0, 99);
            if (r < 5) begin
                // anywhere in the index space, range kept short so walks stay bounded
                f = $urandom_range(0, 131071);
                l = f + $urandom_range(0, 15);
            end else if (r < 10) begin
                l = f - 1;
            end
            if (f > 131071) f = 131071;
            if (l > 131071) l = 131071;
            if (l < 0) l = 0;
            push_action(m, f, l);
        end
    endtask

    initial begin
        r_parity = 0; r_halt = 0; r_sclean = 0; r_count = rbse_pkg::MAX_CHUNKS; r_shift = 9;
        foreach (chunk_st[i]) chunk_st[i] = rbse_pkg::ST_UNW;
        foreach (blk_mark[i]) blk_mark[i] = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, every mode, range edges
        push_action(rbse_pkg::MODE_WRITE, 0, 0);
        push_action(rbse_pkg::MODE_WRITE, 130047, 130047);
        push_action(rbse_pkg::MODE_WRITE, 3, 7);
        push_action(rbse_pkg::MODE_WRITE, 600, 602);
        push_action(MODE_DAEMON, 3, 4);
        push_action(MODE_RELOAD, 5, 5);
        push_action(rbse_pkg::MODE_STALE, 3, 8);
        push_action(MODE_SYNC, 3, 8);
        push_action(MODE_ENDSYNC, 3, 4);
        push_action(MODE_ABORT, 5, 6);
        push_action(MODE_DISCARD, 6, 6);
        push_action(MODE_SYNC, 5, 5);
        push_action(MODE_RELOAD, 5, 5);
        push_action(rbse_pkg::MODE_FLUSH, 0, 0);
        push_action(rbse_pkg::MODE_FLUSH, 0, 0);
        push_action(rbse_pkg::MODE_FLUSH, 131071, 0);
        push_action(rbse_pkg::MODE_WRITE, 130040, 131071);
        push_action(rbse_pkg::MODE_WRITE, 131071, 131071);
        push_action(rbse_pkg::MODE_WRITE, 9, 8);
        push_action(MODE_BAD_LO, 0, 10);
        push_action(MODE_BAD_HI, 0, 10);
        push_action(rbse_pkg::MODE_INIT, 0, 0);
        drain();

        // corner settings
        set_config(1, 0, 1, 1, 15);
        push_action(rbse_pkg::MODE_INIT, 0, 0);
        push_action(rbse_pkg::MODE_WRITE, 0, 131071);
        push_action(rbse_pkg::MODE_WRITE, 1, 1);
        fill_random(20);
        drain();
        set_config(0, 0, 0, 0, 0);
        fill_random(20);
        drain();
        set_config(1, 0, 1, 131071, 12);
        fill_random(20);
        drain();
        set_config(0, 1, 1, 40, 9);
        fill_random(40);
        drain();

        // random phases, small stores to keep block scans short
        for (int ph = 0; ph < 12; ph++) begin
            gaps_on = (ph % 4) != 3;
            set_config(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0,
                       1'($urandom_range(0, 1)), $urandom_range(1, 300),
                       $urandom_range(0, 15));
            fill_random(100);
            drain();
        end

        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
